### sv/cgp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CGP window filter package
// Shared item type, gene and function codes, and the block function.
// ----------------------------------------------------------------------------
package cgp_pkg;

	localparam int WIN_N   = 9;
	localparam int SLOT_N  = 3;
	localparam int NODE_N  = 64;
	localparam int SRC_W   = 6;
	localparam int FN_W    = 5;
	localparam int IDX_W   = 7;
	localparam int PIX_W   = 8;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [SRC_W-1:0] src_t;
	typedef logic [FN_W-1:0]  fn_t;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_FILTER = 1'b1;

	localparam int SLOT_A  = 0;
	localparam int SLOT_B  = 1;
	localparam int SLOT_FN = 2;

	localparam fn_t FN_ONES    = 5'd0;
	localparam fn_t FN_PASS    = 5'd1;
	localparam fn_t FN_NOT     = 5'd2;
	localparam fn_t FN_OR      = 5'd3;
	localparam fn_t FN_ORN     = 5'd4;
	localparam fn_t FN_AND     = 5'd5;
	localparam fn_t FN_NAND    = 5'd6;
	localparam fn_t FN_XOR     = 5'd7;
	localparam fn_t FN_SHR1    = 5'd8;
	localparam fn_t FN_SHR2    = 5'd9;
	localparam fn_t FN_SWAP    = 5'd10;
	localparam fn_t FN_ADD     = 5'd11;
	localparam fn_t FN_ADDS    = 5'd12;
	localparam fn_t FN_AVG     = 5'd13;
	localparam fn_t FN_MAX     = 5'd14;
	localparam fn_t FN_MIN     = 5'd15;
	localparam fn_t FN_DAMAGED = 5'd16;
	localparam fn_t FN_SAT     = 5'd31;

	// one beat through the column pipeline; node holds every source a gene can name
	typedef struct packed {
		logic                    mode;
		logic [IDX_W-1:0]        gene_index;
		src_t                    gene_value;
		pix_t [NODE_N-1:0]       node;
	} item_t;

	function automatic pix_t blk_fn(fn_t f, pix_t x, pix_t y);
		logic [PIX_W:0] sum;
		pix_t r;
		sum = {1'b0, x} + {1'b0, y};
		case (f)
			FN_ONES:    r = '1;
			FN_PASS:    r = x;
			FN_NOT:     r = ~x;
			FN_OR:      r = x | y;
			FN_ORN:     r = ~x | y;
			FN_AND:     r = x & y;
			FN_NAND:    r = ~(x & y);
			FN_XOR:     r = x ^ y;
			FN_SHR1:    r = x >> 1;
			FN_SHR2:    r = x >> 2;
			FN_SWAP:    r = {x[3:0], y[7:4]};
			FN_ADD:     r = sum[PIX_W-1:0];
			FN_ADDS:    r = sum[PIX_W] ? '1 : sum[PIX_W-1:0];
			FN_AVG:     r = sum[PIX_W:1];
			FN_MAX:     r = (x > y) ? x : y;
			FN_MIN:     r = (x < y) ? x : y;
			FN_DAMAGED: r = '0;
			default:    r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/cgp_col.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CGP column stage
// Holds the genes of one column, evaluates its blocks on a passing window
// and registers the beat; gene writes update this column as they pass.
// ----------------------------------------------------------------------------
module cgp_col #(
	parameter int COL  = 0,
	parameter int ROWS = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 up_valid,
	output logic                up_ready,
	input  wire cgp_pkg::item_t up_item,
	output logic                dn_valid,
	input  wire                 dn_ready,
	output cgp_pkg::item_t      dn_item
);
	import cgp_pkg::*;

	localparam int NB  = WIN_N + COL * ROWS;

	src_t [ROWS-1:0] src_a_q;
	src_t [ROWS-1:0] src_b_q;
	fn_t  [ROWS-1:0] fn_q;
	pix_t [ROWS-1:0] res;
	logic            vld_s1;
	item_t           item_s1;
	item_t           nxt;
	logic            take;
	fn_t             fn_in;

	assign up_ready = !vld_s1 || dn_ready;
	assign take     = up_valid && up_ready;
	assign fn_in    = up_item.gene_value[SRC_W-1] ? FN_SAT : up_item.gene_value[FN_W-1:0];

	// sources at or beyond this column read zero
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			res[r] = blk_fn(fn_q[r],
				(int'(src_a_q[r]) < NB) ? up_item.node[src_a_q[r]] : '0,
				(int'(src_b_q[r]) < NB) ? up_item.node[src_b_q[r]] : '0);
		end
	end

	always_comb begin
		nxt = up_item;
		for (int r = 0; r < ROWS; r++) begin
			if (NB + r < NODE_N) begin
				nxt.node[SRC_W'(NB + r)] = res[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_a_q <= '0;
			src_b_q <= '0;
			fn_q    <= '0;
		end else if (take && up_item.mode == MODE_WRITE) begin
			for (int r = 0; r < ROWS; r++) begin
				if (int'(up_item.gene_index) == (COL * ROWS + r) * SLOT_N + SLOT_A) begin
					src_a_q[r] <= up_item.gene_value;
				end
				if (int'(up_item.gene_index) == (COL * ROWS + r) * SLOT_N + SLOT_B) begin
					src_b_q[r] <= up_item.gene_value;
				end
				if (int'(up_item.gene_index) == (COL * ROWS + r) * SLOT_N + SLOT_FN) begin
					fn_q[r] <= fn_in;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= nxt;
		end
	end

	assign dn_valid = vld_s1;
	assign dn_item  = item_s1;

endmodule
`default_nettype wire

### sv/cgp_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CGP output stage
// Holds the output gene, picks the circuit result for filter beats and
// drops gene-write beats after applying an output gene write.
// ----------------------------------------------------------------------------
module cgp_out #(
	parameter int BLOCKS = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 up_valid,
	output logic                up_ready,
	input  wire cgp_pkg::item_t up_item,
	output logic                dn_valid,
	input  wire                 dn_ready,
	output cgp_pkg::pix_t       dn_pixel
);
	import cgp_pkg::*;

	src_t  out_gene_q;
	logic  vld_s1;
	pix_t  pix_s1;
	logic  take;

	assign up_ready = !vld_s1 || dn_ready;
	assign take     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_gene_q <= '0;
		end else if (take && up_item.mode == MODE_WRITE
				&& int'(up_item.gene_index) == BLOCKS * SLOT_N) begin
			out_gene_q <= up_item.gene_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid && up_item.mode == MODE_FILTER;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1 <= (int'(out_gene_q) < WIN_N + BLOCKS) ? up_item.node[out_gene_q] : '0;
		end
	end

	assign dn_valid = vld_s1;
	assign dn_pixel = pix_s1;

endmodule
`default_nettype wire

### sv/cgp_window_filter_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CGP window filter evaluator
// Evaluates a grid of two-input blocks on a 3x3 pixel window, one column
// per pipeline stage; gene writes travel the same pipeline in order.
//
//   channel   handshake                    payload
//   item      item_valid / item_ready      mode, gene_index, gene_value, window_0..8
//   result    result_valid / result_ready  filtered_pixel
//
// One beat per cycle is accepted when the result side does not stall.
// Each beat passes one register stage per column of blocks,
// then the output-gene select stage.
// Gene-write beats give no result and leave at the output stage.
// Reset clears all genes to zero and empties the pipeline.
// A stall holds every full stage; empty stages still fill behind it.
// ----------------------------------------------------------------------------
module cgp_window_filter_eval #(
	parameter int COLUMNS = 8,
	parameter int ROWS    = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  wire                 mode,
	input  wire  [6:0]          gene_index,
	input  wire  [5:0]          gene_value,
	input  wire  [7:0]          window_0,
	input  wire  [7:0]          window_1,
	input  wire  [7:0]          window_2,
	input  wire  [7:0]          window_3,
	input  wire  [7:0]          window_4,
	input  wire  [7:0]          window_5,
	input  wire  [7:0]          window_6,
	input  wire  [7:0]          window_7,
	input  wire  [7:0]          window_8,
	output logic                result_valid,
	input  wire                 result_ready,
	output logic [7:0]          filtered_pixel
);
	import cgp_pkg::*;

	item_t in_item;
	item_t chain_item [COLUMNS+1];
	logic  chain_vld  [COLUMNS+1];
	logic  chain_rdy  [COLUMNS+1];

	always_comb begin
		in_item            = '0;
		in_item.mode       = mode;
		in_item.gene_index = gene_index;
		in_item.gene_value = gene_value;
		in_item.node[0]    = window_0;
		in_item.node[1]    = window_1;
		in_item.node[2]    = window_2;
		in_item.node[3]    = window_3;
		in_item.node[4]    = window_4;
		in_item.node[5]    = window_5;
		in_item.node[6]    = window_6;
		in_item.node[7]    = window_7;
		in_item.node[8]    = window_8;
	end

	assign chain_item[0] = in_item;
	assign chain_vld[0]  = item_valid;
	assign item_ready    = chain_rdy[0];

	for (genvar c = 0; c < COLUMNS; c++) begin : g_col
		cgp_col #(
			.COL  (c),
			.ROWS (ROWS)
		) u_col (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_vld[c]),
			.up_ready (chain_rdy[c]),
			.up_item  (chain_item[c]),
			.dn_valid (chain_vld[c+1]),
			.dn_ready (chain_rdy[c+1]),
			.dn_item  (chain_item[c+1])
		);
	end

	cgp_out #(
		.BLOCKS (COLUMNS * ROWS)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_vld[COLUMNS]),
		.up_ready (chain_rdy[COLUMNS]),
		.up_item  (chain_item[COLUMNS]),
		.dn_valid (result_valid),
		.dn_ready (result_ready),
		.dn_pixel (filtered_pixel)
	);

endmodule
`default_nettype wire

### sv/cgp_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CGP window filter port checker
// Watches the top-level ports for reset, back-pressure and hold behavior.
// ----------------------------------------------------------------------------
module cgp_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        item_valid,
	input wire        item_ready,
	input wire        result_valid,
	input wire        result_ready,
	input wire  [7:0] filtered_pixel
);

	// reset empties the result register
	a_rst_empty: assert property (@(posedge clk) $rose(arst_n) |-> !result_valid)
		else $error("result_valid high out of reset");

	// a free output stage lets the whole column chain take a beat
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid || result_ready) |-> item_ready)
		else $error("item_ready low while output stage can drain");

	// hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(filtered_pixel)))
		else $error("stalled result beat changed");

	// hold an offered input beat until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_ready) |=> item_valid)
		else $error("input beat dropped before accept");

endmodule

bind cgp_window_filter_eval cgp_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.filtered_pixel (filtered_pixel)
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CGP window filter evaluator testbench
// Loads genomes and filters 3x3 windows through the block. A local gene
// store and circuit evaluator predict every filtered pixel, and a monitor
// compares each result beat in order. Both handshakes idle and stall at
// random, and one long result stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
	import cgp_pkg::*;

	localparam int GRID_COLS    = 8;
	localparam int GRID_ROWS    = 4;
	localparam int BLOCK_N      = GRID_COLS * GRID_ROWS;
	localparam int NODE_BASE    = WIN_N;
	localparam int ITEM_TARGET  = 1650;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_SLACK  = GRID_COLS + 4;
	localparam int CYCLE_LIMIT  = 400000;

	typedef logic [IDX_W-1:0] gidx_t;
	typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_CYCLIC} sink_style_t;

	localparam gidx_t OUT_GENE_IDX = gidx_t'(BLOCK_N * SLOT_N);
	localparam fn_t   FN_UNKNOWN   = 5'd17;
	localparam src_t  VAL_MAX      = '1;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_ready;
	logic  mode = MODE_WRITE;
	gidx_t gene_index = '0;
	src_t  gene_value = '0;
	pix_t  window_0 = '0, window_1 = '0, window_2 = '0;
	pix_t  window_3 = '0, window_4 = '0, window_5 = '0;
	pix_t  window_6 = '0, window_7 = '0, window_8 = '0;
	logic  result_valid;
	logic  result_ready = 1'b0;
	pix_t  filtered_pixel;

	cgp_window_filter_eval #(
		.COLUMNS(GRID_COLS),
		.ROWS   (GRID_ROWS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.mode          (mode),
		.gene_index    (gene_index),
		.gene_value    (gene_value),
		.window_0      (window_0),
		.window_1      (window_1),
		.window_2      (window_2),
		.window_3      (window_3),
		.window_4      (window_4),
		.window_5      (window_5),
		.window_6      (window_6),
		.window_7      (window_7),
		.window_8      (window_8),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.filtered_pixel(filtered_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gene store and window seen by the circuit evaluator
	src_t genome_a [BLOCK_N];
	src_t genome_b [BLOCK_N];
	fn_t  genome_fn [BLOCK_N];
	src_t genome_out;
	pix_t stim_win [WIN_N];
	pix_t node_val [BLOCK_N];

	pix_t pending_pixels [$];

	int  beat_count, write_count, filter_count, genome_count;
	int  checked_count, fail_count, cycle_count;
	int  burst_left;
	bit  steady_sender;
	bit  hold_request;

	function automatic pix_t apply_fn(fn_t f, pix_t x, pix_t y);
		logic [PIX_W:0] wide;
		wide = {1'b0, x} + {1'b0, y};
		case (f)
			FN_ONES:  return 8'hFF;
			FN_PASS:  return x;
			FN_NOT:   return x ^ 8'hFF;
			FN_OR:    return x | y;
			FN_ORN:   return (x ^ 8'hFF) | y;
			FN_AND:   return x & y;
			FN_NAND:  return (x & y) ^ 8'hFF;
			FN_XOR:   return x ^ y;
			FN_SHR1:  return {1'b0, x[7:1]};
			FN_SHR2:  return {2'b00, x[7:2]};
			FN_SWAP:  return {x[3:0], y[7:4]};
			FN_ADD:   return wide[PIX_W-1:0];
			FN_ADDS:  return (wide > 9'd255) ? 8'hFF : wide[PIX_W-1:0];
			FN_AVG:   return wide[PIX_W:1];
			FN_MAX:   return (x >= y) ? x : y;
			FN_MIN:   return (x <= y) ? x : y;
			default:  return 8'h00;
		endcase
	endfunction

	function automatic pix_t fetch_src(src_t s, int col, bit any_block);
		int k;
		if (s < WIN_N) return stim_win[s];
		k = int'(s) - NODE_BASE;
		if (k >= BLOCK_N) return 8'h00;
		if (!any_block && (k / GRID_ROWS) >= col) return 8'h00;
		return node_val[k];
	endfunction

	function automatic pix_t eval_circuit();
		int col;
		for (int b = 0; b < BLOCK_N; b++) begin
			col = b / GRID_ROWS;
			node_val[b] = apply_fn(genome_fn[b], fetch_src(genome_a[b], col, 1'b0),
				fetch_src(genome_b[b], col, 1'b0));
		end
		return fetch_src(genome_out, 0, 1'b1);
	endfunction

	function automatic void record_gene(gidx_t idx, src_t val);
		int b;
		int slot;
		if (idx < OUT_GENE_IDX) begin
			b = idx / SLOT_N;
			slot = idx % SLOT_N;
			case (slot)
				SLOT_A:  genome_a[b] = val;
				SLOT_B:  genome_b[b] = val;
				default: genome_fn[b] = (val > FN_SAT) ? FN_SAT : fn_t'(val);
			endcase
		end else if (idx == OUT_GENE_IDX) begin
			genome_out = val;
		end
	endfunction

	function automatic gidx_t gene_at(int blk, int slot);
		return gidx_t'(blk * SLOT_N + slot);
	endfunction

	function automatic src_t pick_gene(int blk, int slot);
		int roll;
		roll = $urandom_range(0, 99);
		if (slot == SLOT_FN) begin
			if (roll < 85) return src_t'($urandom_range(FN_ONES, FN_DAMAGED));
			if (roll < 95) return src_t'($urandom_range(FN_ONES, FN_SAT));
			return src_t'($urandom);
		end
		if (roll < 90) return src_t'($urandom_range(0, NODE_BASE + (blk / GRID_ROWS) * GRID_ROWS - 1));
		return src_t'($urandom);
	endfunction

	function automatic src_t pick_output();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7) return src_t'(NODE_BASE + $urandom_range(BLOCK_N / 2, BLOCK_N - 1));
		if (roll < 9) return src_t'($urandom_range(0, NODE_BASE + BLOCK_N - 1));
		return src_t'($urandom);
	endfunction

	function automatic void rand_window();
		foreach (stim_win[i]) begin
			case ($urandom_range(0, 7))
				0:       stim_win[i] = 8'h00;
				1:       stim_win[i] = 8'hFF;
				default: stim_win[i] = pix_t'($urandom);
			endcase
		end
	endfunction

	task automatic send_beat(input logic m, input gidx_t idx, input src_t val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = steady_sender ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		mode       <= m;
		gene_index <= idx;
		gene_value <= val;
		window_0   <= stim_win[0];
		window_1   <= stim_win[1];
		window_2   <= stim_win[2];
		window_3   <= stim_win[3];
		window_4   <= stim_win[4];
		window_5   <= stim_win[5];
		window_6   <= stim_win[6];
		window_7   <= stim_win[7];
		window_8   <= stim_win[8];
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		beat_count++;
		if (m == MODE_FILTER) begin
			pending_pixels.insert(pending_pixels.size(), eval_circuit());
			filter_count++;
		end else begin
			record_gene(idx, val);
			write_count++;
		end
	endtask

	task automatic write_gene(input gidx_t idx, input src_t val);
		rand_window();
		send_beat(MODE_WRITE, idx, val);
	endtask

	task automatic filter_window();
		send_beat(MODE_FILTER, gidx_t'($urandom), src_t'($urandom));
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		burst_left = 0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_genome();
		for (int b = 0; b < BLOCK_N; b++)
			for (int s = 0; s < SLOT_N; s++)
				write_gene(gene_at(b, s), pick_gene(b, s));
		write_gene(OUT_GENE_IDX, pick_output());
		genome_count++;
	endtask

	task automatic test_reset_state();
		rand_window();
		stim_win[0] = 8'hFF;
		filter_window();
		foreach (stim_win[i]) stim_win[i] = 8'hFF;
		stim_win[0] = 8'h00;
		filter_window();
	endtask

	task automatic test_each_function();
		write_gene(gene_at(0, SLOT_B), src_t'(1));
		write_gene(OUT_GENE_IDX, src_t'(NODE_BASE));
		for (int f = FN_ONES; f <= FN_UNKNOWN; f++) begin
			write_gene(gene_at(0, SLOT_FN), src_t'(f));
			rand_window();
			case (f % 4)
				0: begin stim_win[0] = 8'hFF; stim_win[1] = 8'h00; end
				1: begin stim_win[0] = 8'h00; stim_win[1] = 8'hFF; end
				2: begin stim_win[0] = 8'hFF; stim_win[1] = 8'hFF; end
				default: ;
			endcase
			filter_window();
		end
	endtask

	task automatic test_gene_rules();
		// function value past the field clamps to an unknown code
		write_gene(gene_at(0, SLOT_FN), VAL_MAX);
		rand_window();
		filter_window();
		write_gene(gene_at(0, SLOT_FN), src_t'(FN_PASS));
		write_gene(gene_at(4, SLOT_FN), src_t'(FN_PASS));
		write_gene(OUT_GENE_IDX, src_t'(NODE_BASE + 4));
		// block in the same column, an earlier one, a later one, past the grid
		write_gene(gene_at(4, SLOT_A), src_t'(NODE_BASE + 4));
		rand_window();
		filter_window();
		write_gene(gene_at(4, SLOT_A), src_t'(NODE_BASE));
		rand_window();
		filter_window();
		write_gene(gene_at(4, SLOT_A), src_t'(NODE_BASE + BLOCK_N - 1));
		rand_window();
		filter_window();
		write_gene(gene_at(4, SLOT_A), src_t'(NODE_BASE + BLOCK_N));
		rand_window();
		filter_window();
		write_gene(gene_at(4, SLOT_A), src_t'(NODE_BASE));
		// indexes past the output gene are dropped
		write_gene(gidx_t'(OUT_GENE_IDX + 1), '0);
		write_gene('1, '0);
		rand_window();
		filter_window();
		write_gene(OUT_GENE_IDX, src_t'(NODE_BASE + BLOCK_N));
		rand_window();
		filter_window();
		write_gene(OUT_GENE_IDX, VAL_MAX);
		rand_window();
		filter_window();
	endtask

	task automatic test_backpressure();
		write_genome();
		wait_drain();
		steady_sender = 1'b1;
		hold_request = 1'b1;
		repeat (48) begin
			rand_window();
			filter_window();
		end
		steady_sender = 1'b0;
		wait_drain();
	endtask

	task automatic test_random_genomes();
		int roll;
		while (beat_count < ITEM_TARGET) begin
			steady_sender = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				write_genome();
			end else if (roll <= 5) begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 7) == 0) begin
						write_gene(OUT_GENE_IDX, pick_output());
					end else begin
						int b;
						int s;
						b = $urandom_range(0, BLOCK_N - 1);
						s = $urandom_range(SLOT_A, SLOT_FN);
						write_gene(gene_at(b, s), pick_gene(b, s));
					end
				end
			end else if (roll == 6) begin
				repeat ($urandom_range(1, 4)) write_gene(gidx_t'($urandom), src_t'($urandom));
			end
			repeat ($urandom_range(4, 40)) begin
				rand_window();
				filter_window();
			end
			if ($urandom_range(0, 9) == 0) wait_drain();
		end
		steady_sender = 1'b0;
	endtask

	initial begin : result_sink
		sink_style_t style;
		int style_left;
		int hold_left;
		int phase;
		style = SINK_OPEN;
		style_left = 0;
		hold_left = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (style_left == 0) begin
				style = sink_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(64, 320);
			end
			style_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				case (style)
					SINK_OPEN:  result_ready <= 1'b1;
					SINK_LIGHT: result_ready <= ($urandom_range(0, 3) != 0);
					SINK_HEAVY: result_ready <= ($urandom_range(0, 3) == 0);
					default:    result_ready <= ((phase % 8) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("filtered_pixel: no result expected, got %0d", filtered_pixel);
				fail_count++;
			end else begin
				pix_t want;
				want = pending_pixels.pop_front();
				checked_count++;
				if (filtered_pixel !== want) begin
					$error("filtered_pixel: expected %0d, got %0d", want, filtered_pixel);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		for (int b = 0; b < BLOCK_N; b++) begin
			genome_a[b] = '0;
			genome_b[b] = '0;
			genome_fn[b] = '0;
		end
		genome_out = '0;
		foreach (stim_win[i]) stim_win[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_each_function();
		test_gene_rules();
		wait_drain();
		test_backpressure();
		test_random_genomes();
		wait_drain();

		$display("covered %0d gene writes (%0d full genomes) and %0d filtered windows",
			write_count, genome_count, filter_count);
		$display("compared %0d pixels, %0d failures", checked_count, fail_count);
		if (fail_count == 0 && pending_pixels.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
